FILE: rtl/ses_pkg.sv
// ----------------------------------------------------------------------------
// ses_pkg: shared types and constants of the step exchange sorter
// Store geometry, record layout and the request and status structs that
// pass between the top level and the sort sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ses_pkg;

  localparam int DEPTH     = 32;
  localparam int KEY_WIDTH = 32;
  localparam int TAG_WIDTH = 16;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int REC_W = KEY_WIDTH + TAG_WIDTH;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

  // Pass direction codes
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // Mode register codes
  localparam logic MODE_ALT     = 1'b0;
  localparam logic MODE_UP_ONLY = 1'b1;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
  } rec_t;

  // Store request: one write port, one registered read port
  typedef struct packed {
    logic we;
    idx_t waddr;
    rec_t wdata;
    logic re;
    idx_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic go;
    cnt_t n;
  } sort_ctl_t;

  typedef struct packed {
    logic done;
    logic active;
  } sort_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ses_ram.sv
// ----------------------------------------------------------------------------
// ses_ram: generic single-write, single-read RAM
// One write and one registered read per cycle. Contents have no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ses_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/ses_sort.sv
// ----------------------------------------------------------------------------
// ses_sort: step exchange sort sequencer
// Runs step-up (and, in MODE_ALT, step-down) passes on the store through one
// shared key comparator, one store read per step and two writes per swap.
// ----------------------------------------------------------------------------
`default_nettype none

module ses_sort import ses_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      mode,
  input  wire sort_ctl_t ctl,
  input  wire rec_t      rdata,
  output      sort_sts_t sts,
  output      mem_req_t  req
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PINIT = 3'd1;
  localparam logic [2:0] S_PV    = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_W1    = 3'd5;
  localparam logic [2:0] S_W2    = 3'd6;
  localparam logic [2:0] S_ENDP  = 3'd7;

  logic [2:0] st_r, st_nxt;
  logic       dir_r, dir_nxt;
  logic       done_r, done_nxt;
  idx_t       lo_r, lo_nxt;
  idx_t       hi_r, hi_nxt;
  idx_t       pivot_r, pivot_nxt;
  idx_t       cur_r, cur_nxt;
  idx_t       nx_r, nx_nxt;
  idx_t       anchor_r, anchor_nxt;
  idx_t       x_r, x_nxt;
  rec_t       pv_r, pv_nxt;
  rec_t       prev_r, prev_nxt;
  rec_t       swap_r, swap_nxt;

  logic       gt;
  logic       edge_ok;
  idx_t       hi_new;
  idx_t       lo_new;

  // Shared comparator: operands swap with the pass direction
  always_comb begin
    if (dir_r == DIR_UP) begin
      gt = pv_r.key > rdata.key;
    end else begin
      gt = rdata.key > pv_r.key;
    end
  end

  // Neighbor of the next slot still lies inside the bound
  assign edge_ok = (dir_r == DIR_UP) ? (nx_r < hi_r) : (nx_r > lo_r);
  assign hi_new  = anchor_r - idx_t'(1);
  assign lo_new  = anchor_r + idx_t'(1);

  // Sequencer
  always_comb begin
    st_nxt     = st_r;
    dir_nxt    = dir_r;
    done_nxt   = 1'b0;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    pivot_nxt  = pivot_r;
    cur_nxt    = cur_r;
    nx_nxt     = nx_r;
    anchor_nxt = anchor_r;
    x_nxt      = x_r;
    pv_nxt     = pv_r;
    prev_nxt   = prev_r;
    swap_nxt   = swap_r;
    req        = '0;
    unique case (st_r)
      S_IDLE: begin
        if (ctl.go) begin
          lo_nxt  = '0;
          hi_nxt  = idx_t'(ctl.n - cnt_t'(1));
          dir_nxt = DIR_UP;
          if (ctl.n <= cnt_t'(1)) begin
            done_nxt = 1'b1;
          end else begin
            st_nxt = S_PINIT;
          end
        end
      end
      S_PINIT: begin
        // Set up the pass and fetch the starting pivot
        if (dir_r == DIR_UP) begin
          pivot_nxt  = lo_r;
          cur_nxt    = lo_r;
          anchor_nxt = lo_r + idx_t'(1);
          req.raddr  = lo_r;
        end else begin
          pivot_nxt  = hi_r;
          cur_nxt    = hi_r;
          anchor_nxt = hi_r - idx_t'(1);
          req.raddr  = hi_r;
        end
        if (lo_r < hi_r) begin
          req.re = 1'b1;
          st_nxt = S_PV;
        end else begin
          st_nxt = S_ENDP;
        end
      end
      S_PV: begin
        pv_nxt   = rdata;
        prev_nxt = rdata;
        st_nxt   = S_RD;
      end
      S_RD: begin
        nx_nxt    = (dir_r == DIR_UP) ? cur_r + idx_t'(1) : cur_r - idx_t'(1);
        req.re    = 1'b1;
        req.raddr = nx_nxt;
        st_nxt    = S_CMP;
      end
      S_CMP: begin
        prev_nxt = rdata;
        priority if (gt && edge_ok) begin
          // Smaller neighbor: advance the cursor only
          cur_nxt = nx_r;
          st_nxt  = S_RD;
        end else if (gt) begin
          // Last slot is smaller: swap it with the pivot
          x_nxt    = nx_r;
          swap_nxt = rdata;
          st_nxt   = S_W1;
        end else if (cur_r == pivot_r) begin
          // Pivot moves on to the neighbor
          pivot_nxt = nx_r;
          cur_nxt   = nx_r;
          pv_nxt    = rdata;
          st_nxt    = edge_ok ? S_RD : S_ENDP;
        end else begin
          x_nxt    = cur_r;
          swap_nxt = prev_r;
          st_nxt   = S_W1;
        end
      end
      S_W1: begin
        req.we    = 1'b1;
        req.waddr = pivot_r;
        req.wdata = swap_r;
        st_nxt    = S_W2;
      end
      S_W2: begin
        req.we     = 1'b1;
        req.waddr  = x_r;
        req.wdata  = pv_r;
        anchor_nxt = x_r;
        pivot_nxt  = nx_r;
        cur_nxt    = nx_r;
        pv_nxt     = prev_r;
        st_nxt     = edge_ok ? S_RD : S_ENDP;
      end
      S_ENDP: begin
        // Trim the bound and pick the next pass
        if (dir_r == DIR_UP) begin
          hi_nxt = hi_new;
          if (mode == MODE_ALT) begin
            dir_nxt = DIR_DOWN;
            st_nxt  = S_PINIT;
          end else if (lo_r < hi_new) begin
            st_nxt = S_PINIT;
          end else begin
            done_nxt = 1'b1;
            st_nxt   = S_IDLE;
          end
        end else begin
          lo_nxt = lo_new;
          if (lo_new < hi_r) begin
            dir_nxt = DIR_UP;
            st_nxt  = S_PINIT;
          end else begin
            done_nxt = 1'b1;
            st_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  // Pass bounds, indexes and held records
  always_ff @(posedge clk) begin
    dir_r    <= dir_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    pivot_r  <= pivot_nxt;
    cur_r    <= cur_nxt;
    nx_r     <= nx_nxt;
    anchor_r <= anchor_nxt;
    x_r      <= x_nxt;
    pv_r     <= pv_nxt;
    prev_r   <= prev_nxt;
    swap_r   <= swap_nxt;
  end

  assign sts.done   = done_r;
  assign sts.active = (st_r != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/step_exchange_sorter_unit.sv
// ----------------------------------------------------------------------------
// step_exchange_sorter_unit: keyed record sorter, top level
// Loads records, sorts them by unsigned key and emits them in order.
// ----------------------------------------------------------------------------
// Records load one per cycle while busy is low; a record with in_last high
// closes the set and starts the sort, with busy high until the last result
// has been issued. Up to DEPTH records are held; later ones are dropped and
// out_overflow is high on every result of that run. The sort runs over a
// record store with one write and one registered read port through one
// shared key comparator: each compare step reads the neighbor and compares,
// a swap adds two writes, and each pass adds set-up and end steps. Results
// then follow on consecutive cycles, one per record, each on the ports for
// exactly one cycle with out_strobe high; the receiver cannot hold them off,
// and the final one carries out_last_res. The next set may start loading in
// the cycle that shows the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module step_exchange_sorter_unit import ses_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [KEY_WIDTH-1:0] in_key,
  input  wire logic [TAG_WIDTH-1:0] in_tag,
  input  wire logic                 in_last,
  output      logic                 out_strobe,
  output      logic [KEY_WIDTH-1:0] out_key_res,
  output      logic [TAG_WIDTH-1:0] out_tag_res,
  output      logic                 out_last_res,
  output      logic                 out_overflow
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_SORT = 2'd1;
  localparam logic [1:0] T_EMIT = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic       mode_r;
  cnt_t       count_r, count_nxt;
  logic       dropped_r, dropped_nxt;
  logic       go_r, go_nxt;
  cnt_t       emit_r, emit_nxt;
  logic       strobe_r, strobe_nxt;
  logic       last_r, last_nxt;
  logic       ovf_r, ovf_nxt;

  logic       accept;
  logic       emit_final;
  mem_req_t   mem;
  mem_req_t   sort_req;
  sort_ctl_t  sort_ctl;
  sort_sts_t  sort_sts;
  rec_t       rdata;

  assign busy       = (st_r != T_IDLE);
  assign accept     = start && !busy;
  assign emit_final = (emit_r == cnt_t'(count_r - cnt_t'(1)));

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ALT;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Load, sort and emit control
  always_comb begin
    st_nxt      = st_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    go_nxt      = 1'b0;
    emit_nxt    = emit_r;
    strobe_nxt  = 1'b0;
    last_nxt    = 1'b0;
    ovf_nxt     = ovf_r;
    unique case (st_r)
      T_IDLE: begin
        if (accept) begin
          if (count_r < DEPTH_CNT) begin
            count_nxt = count_r + cnt_t'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            go_nxt = 1'b1;
            st_nxt = T_SORT;
          end
        end
      end
      T_SORT: begin
        if (sort_sts.done) begin
          emit_nxt = '0;
          st_nxt   = T_EMIT;
        end
      end
      T_EMIT: begin
        // Issue one read per cycle; the result shows the next cycle
        strobe_nxt = 1'b1;
        last_nxt   = emit_final;
        ovf_nxt    = dropped_r;
        emit_nxt   = emit_r + cnt_t'(1);
        if (emit_final) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          st_nxt      = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  // Store port selection
  always_comb begin
    mem = '0;
    unique case (st_r)
      T_IDLE: begin
        mem.we       = accept && (count_r < DEPTH_CNT);
        mem.waddr    = count_r[IDX_W-1:0];
        mem.wdata.key = in_key;
        mem.wdata.tag = in_tag;
      end
      T_SORT: begin
        mem = sort_req;
      end
      T_EMIT: begin
        mem.re    = 1'b1;
        mem.raddr = emit_r[IDX_W-1:0];
      end
      default: begin
        mem = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= T_IDLE;
      count_r   <= '0;
      dropped_r <= 1'b0;
      go_r      <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      go_r      <= go_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_r <= emit_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign sort_ctl.go = go_r;
  assign sort_ctl.n  = count_r;

  ses_sort u_sort (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (mode_r),
    .ctl   (sort_ctl),
    .rdata (rdata),
    .sts   (sort_sts),
    .req   (sort_req)
  );

  ses_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  assign out_strobe   = strobe_r;
  assign out_key_res  = rdata.key;
  assign out_tag_res  = rdata.tag;
  assign out_last_res = last_r && strobe_r;
  assign out_overflow = ovf_r;

  // A result transaction only follows a cycle in the emit phase
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(st_r) == T_EMIT)
    else $error("result strobe outside emit phase");

  // The sort finishes only while the top waits for it
  a_done_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    sort_sts.done |-> st_r == T_SORT)
    else $error("sort done outside sort phase");

  // The record count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("record count beyond store depth");

  // The sequencer stays idle while the top is loading records
  a_sort_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_IDLE) |-> !sort_sts.active)
    else $error("sort sequencer active while loading");

  // The final result closes the run: the block is free again
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_res |-> !busy && count_r == '0)
    else $error("run not closed at final result");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for step_exchange_sorter_unit
// Loads keyed record sets through the start/busy command port and predicts
// the sorted run with a local copy of the step exchange passes. Each strobed
// result is checked field by field against the oldest predicted record.
// Covers both pass modes, extreme keys, equal keys, single-record sets, full
// stores and dropped records, under several sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import ses_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 4;
  // worst sort plus result burst for a full store
  localparam int DRAIN_CYCLES = 4 * DEPTH * DEPTH + 2 * DEPTH;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
    logic                 last;
    logic                 overflow;
  } sorted_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic                 cfg_wr_data;
  logic                 start;
  logic                 busy;
  logic [KEY_WIDTH-1:0] in_key;
  logic [TAG_WIDTH-1:0] in_tag;
  logic                 in_last;
  logic                 out_strobe;
  logic [KEY_WIDTH-1:0] out_key_res;
  logic [TAG_WIDTH-1:0] out_tag_res;
  logic                 out_last_res;
  logic                 out_overflow;

  // Predictor state: record store, fill level, drop flag and pass mode
  logic [KEY_WIDTH-1:0] key_mem [DEPTH];
  logic [TAG_WIDTH-1:0] tag_mem [DEPTH];
  int                   held_cnt;
  logic                 lost_flag;
  logic                 pass_mode;

  sorted_rec_t sorted_q[$];
  int          mismatch_cnt;
  int          send_idle_pct;

  step_exchange_sorter_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .busy         (busy),
    .in_key       (in_key),
    .in_tag       (in_tag),
    .in_last      (in_last),
    .out_strobe   (out_strobe),
    .out_key_res  (out_key_res),
    .out_tag_res  (out_tag_res),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow)
  );

  // Free-running clock
  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // Exchange two store slots, key and tag together
  function automatic void swap_slots(input int a, input int b);
    logic [KEY_WIDTH-1:0] k;
    logic [TAG_WIDTH-1:0] t;
    k = key_mem[a];
    t = tag_mem[a];
    key_mem[a] = key_mem[b];
    tag_mem[a] = tag_mem[b];
    key_mem[b] = k;
    tag_mem[b] = t;
  endfunction

  // Carry a running pivot upward over [lo, hi]; return the trimmed top bound
  function automatic int climb_pass(input int lo, input int hi);
    int anchor;
    int pivot;
    int a;
    int b;
    anchor = lo + 1;
    pivot  = lo;
    a      = lo;
    while (a < hi) begin
      b = a + 1;
      if (key_mem[pivot] > key_mem[b]) begin
        if (b < hi) begin
          a = b;
          continue;
        end
        a = b;
      end else if (a == pivot) begin
        pivot = b;
        a = b;
        continue;
      end
      swap_slots(pivot, a);
      anchor = a;
      pivot  = b;
      a      = b;
    end
    return anchor - 1;
  endfunction

  // Mirror of the upward pass; return the trimmed bottom bound
  function automatic int descend_pass(input int lo, input int hi);
    int anchor;
    int pivot;
    int a;
    int b;
    anchor = hi - 1;
    pivot  = hi;
    b      = hi;
    while (b > lo) begin
      a = b - 1;
      if (key_mem[a] > key_mem[pivot]) begin
        if (a > lo) begin
          b = a;
          continue;
        end
        b = a;
      end else if (b == pivot) begin
        pivot = a;
        b = a;
        continue;
      end
      swap_slots(pivot, b);
      anchor = b;
      pivot  = a;
      b      = a;
    end
    return anchor + 1;
  endfunction

  // Store one accepted record; on last, sort the set and queue the run
  function automatic void predict_sorted_run(input logic [KEY_WIDTH-1:0] key,
                                             input logic [TAG_WIDTH-1:0] tag,
                                             input logic last);
    sorted_rec_t rec;
    int lo;
    int hi;
    int i;
    if (held_cnt < DEPTH) begin
      key_mem[held_cnt] = key;
      tag_mem[held_cnt] = tag;
      held_cnt++;
    end else begin
      lost_flag = 1'b1;
    end
    if (!last) return;
    if (held_cnt > 1) begin
      lo = 0;
      hi = held_cnt - 1;
      do begin
        hi = climb_pass(lo, hi);
        if (pass_mode == MODE_ALT) lo = descend_pass(lo, hi);
      end while (lo < hi);
    end
    for (i = 0; i < held_cnt; i++) begin
      rec.key      = key_mem[i];
      rec.tag      = tag_mem[i];
      rec.last     = (i == held_cnt - 1);
      rec.overflow = lost_flag;
      sorted_q.push_back(rec);
    end
    held_cnt  = 0;
    lost_flag = 1'b0;
  endfunction

  // Compare each strobed result with the oldest predicted record
  always @(posedge clk) begin : check_results
    sorted_rec_t exp_rec;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected result: key_res %h tag_res %h", out_key_res, out_tag_res);
        mismatch_cnt++;
      end else begin
        exp_rec = sorted_q.pop_front();
        if (out_key_res !== exp_rec.key) begin
          $error("key_res mismatch: expected %h, got %h", exp_rec.key, out_key_res);
          mismatch_cnt++;
        end
        if (out_tag_res !== exp_rec.tag) begin
          $error("tag_res mismatch: expected %h, got %h", exp_rec.tag, out_tag_res);
          mismatch_cnt++;
        end
        if (out_last_res !== exp_rec.last) begin
          $error("last_res mismatch: expected %b, got %b", exp_rec.last, out_last_res);
          mismatch_cnt++;
        end
        if (out_overflow !== exp_rec.overflow) begin
          $error("overflow mismatch: expected %b, got %b", exp_rec.overflow,
                 out_overflow);
          mismatch_cnt++;
        end
      end
    end
  end

  // Issue one record and hold it until the block takes the transaction
  task automatic send_record(input logic [KEY_WIDTH-1:0] key,
                             input logic [TAG_WIDTH-1:0] tag,
                             input logic last);
    int gap;
    gap = 0;
    start   <= 1'b1;
    in_key  <= key;
    in_tag  <= tag;
    in_last <= last;
    do @(posedge clk); while (busy !== 1'b0);
    predict_sorted_run(key, tag, last);
    // idle a random number of cycles, with junk on the data lines
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start   <= 1'b0;
      in_key  <= $urandom;
      in_tag  <= TAG_WIDTH'($urandom);
      in_last <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop issuing and wait until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the mode register while the block is idle
  task automatic set_mode(input logic value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pass_mode = value;
  endtask

  // One-record sets at both key and tag extremes
  task automatic test_single_record();
    set_mode(MODE_ALT);
    send_record('1, '1, 1'b1);
    send_record('0, '0, 1'b1);
  endtask

  // Alternating passes: reversed keys, equal keys, extreme keys
  task automatic test_alternating_passes();
    logic [KEY_WIDTH-1:0] extreme_keys [5];
    logic [TAG_WIDTH-1:0] extreme_tags [5];
    int i;
    extreme_keys = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0000_0001};
    extreme_tags = '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000, 16'h0001};
    set_mode(MODE_ALT);
    for (i = 0; i < 5; i++) send_record(KEY_WIDTH'(5 - i), TAG_WIDTH'(i), i == 4);
    for (i = 0; i < 4; i++) send_record(32'h8000_0000, TAG_WIDTH'(16'h1000 + i), i == 3);
    for (i = 0; i < 5; i++) send_record(extreme_keys[i], extreme_tags[i], i == 4);
  endtask

  // Step-up passes only: unordered duplicates, a two-record swap, a one-record set
  task automatic test_step_up_only();
    logic [KEY_WIDTH-1:0] dup_keys [4];
    int i;
    dup_keys = '{32'd3, 32'd3, 32'd1, 32'd0};
    set_mode(MODE_UP_ONLY);
    for (i = 0; i < 4; i++) send_record(dup_keys[i], TAG_WIDTH'(16'hC000 + i), i == 3);
    send_record('1, 16'h00FF, 1'b0);
    send_record('0, 16'hFF00, 1'b1);
    send_record(32'h1234_5678, 16'h9ABC, 1'b1);
  endtask

  // Random record sets of random size and key pattern, mode changed now and then
  task automatic test_random_traffic(input int idle_pct, input int budget);
    logic [KEY_WIDTH-1:0] base;
    logic [KEY_WIDTH-1:0] step;
    logic [KEY_WIDTH-1:0] key;
    int sent;
    int n;
    int r;
    int style;
    int i;
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0) set_mode(1'($urandom_range(1)));
      r = $urandom_range(99);
      if (r < 65)      n = $urandom_range(1, 8);
      else if (r < 85) n = $urandom_range(9, DEPTH - 1);
      else if (r < 93) n = DEPTH;
      else             n = $urandom_range(DEPTH + 1, DEPTH + 6);
      style = $urandom_range(4);
      base  = $urandom;
      step  = $urandom_range(1, 1000);
      for (i = 0; i < n; i++) begin
        case (style)
          0: key = $urandom;
          1: key = $urandom_range(7);
          2: key = base + KEY_WIDTH'(i) * step;
          3: key = base - KEY_WIDTH'(i) * step;
          default: begin
            r = $urandom_range(4);
            key = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? 32'h8000_0000 :
                  (r == 3) ? 32'h7FFF_FFFF : $urandom;
          end
        endcase
        send_record(key, TAG_WIDTH'($urandom), i == n - 1);
      end
      sent += n;
    end
    drain_results();
  endtask

  // Main sequence
  initial begin
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    start         <= 1'b0;
    in_key        <= '0;
    in_tag        <= '0;
    in_last       <= 1'b0;
    held_cnt      = 0;
    lost_flag     = 1'b0;
    pass_mode     = MODE_ALT;
    mismatch_cnt  = 0;
    send_idle_pct = 21;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_record();
    test_alternating_passes();
    test_step_up_only();
    test_random_traffic(21, 99);
    test_random_traffic(53, 99);
    test_random_traffic(0, 99);
    set_mode(MODE_ALT);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && sorted_q.size() == 0) begin
      $display("PASS");
    end else begin
      if (sorted_q.size() != 0) $error("%0d results never arrived", sorted_q.size());
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ses_pkg.sv
rtl/ses_ram.sv
rtl/ses_sort.sv
rtl/step_exchange_sorter_unit.sv
tb/sv/testbench.sv
